// ===== design/price_sorted_item_table_defines.svh =====
// Assertion macros shared by the price sorted item table RTL.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef PRICE_SORTED_ITEM_TABLE_DEFINES_SVH
`define PRICE_SORTED_ITEM_TABLE_DEFINES_SVH

// condition must hold on every cycle out of reset
`define PSIT_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PSIT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== design/psit_pkg.sv =====
// Package for the price sorted item table: sizes, codes and record types.
// No dependencies.
package psit_pkg;
   localparam int CAPACITY    = 32;
   localparam int KEY_BITS    = 16;
   localparam int PRICE_BITS  = 24;
   localparam int CAT_BITS    = 2;
   localparam int OP_BITS     = 3;
   localparam int STATUS_BITS = 2;
   localparam int IDX_BITS    = $clog2(CAPACITY);
   localparam int CNT_BITS    = $clog2(CAPACITY + 1);

   localparam logic [OP_BITS-1:0] OP_INSERT     = 3'd0;
   localparam logic [OP_BITS-1:0] OP_REMOVE     = 3'd1;
   localparam logic [OP_BITS-1:0] OP_LOOKUP     = 3'd2;
   localparam logic [OP_BITS-1:0] OP_LIST_ALL   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_LIST_CAT   = 3'd4;
   localparam logic [OP_BITS-1:0] OP_LIST_RANGE = 3'd5;

   localparam logic [STATUS_BITS-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 2'd3;

   localparam logic [2:0] KIND_INSERT = 3'd0;
   localparam logic [2:0] KIND_REMOVE = 3'd1;
   localparam logic [2:0] KIND_LOOKUP = 3'd2;
   localparam logic [2:0] KIND_LIST   = 3'd3;
   localparam logic [2:0] KIND_BAD    = 3'd4;

   localparam logic [1:0] MODE_ALL   = 2'd0;
   localparam logic [1:0] MODE_CAT   = 2'd1;
   localparam logic [1:0] MODE_RANGE = 2'd2;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [CAT_BITS-1:0]   cat;
      logic [PRICE_BITS-1:0] price;
   } entry_type;

   typedef struct packed {
      logic [2:0]            kind;
      logic [1:0]            mode;
      entry_type             ent;
      logic [PRICE_BITS-1:0] upper;
   } cmd_type;
endpackage

// ===== design/psit_if.sv =====
// Request and response channel interfaces of the price sorted item table.
// Depends on psit_pkg.
interface psit_req_if;
   import psit_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [OP_BITS-1:0]    opcode;
   logic [KEY_BITS-1:0]   item_key;
   logic [CAT_BITS-1:0]   category;
   logic [PRICE_BITS-1:0] price;
   logic [PRICE_BITS-1:0] price_upper;
   modport source (output valid, opcode, item_key, category, price, price_upper,
                   input ready);
   modport sink (input valid, opcode, item_key, category, price, price_upper,
                 output ready);
endinterface

interface psit_rsp_if;
   import psit_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [KEY_BITS-1:0]    out_key;
   logic [CAT_BITS-1:0]    out_category;
   logic [PRICE_BITS-1:0]  out_price;
   logic                   last;
   modport source (output valid, status, out_key, out_category, out_price, last,
                   input ready);
   modport sink (input valid, status, out_key, out_category, out_price, last,
                 output ready);
endinterface

// ===== design/psit_front.sv =====
// Front end: accepts requests, decodes them into commands, two-deep queue.
// Depends on psit_pkg and psit_req_if.
module psit_front (
   input  logic              clock,
   input  logic              reset,
   psit_req_if.sink          req_chan,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output psit_pkg::cmd_type cmd
);
   import psit_pkg::*;

   cmd_type    q_ff [2];
   cmd_type    dec;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   always_comb begin
      dec.ent.key   = req_chan.item_key;
      dec.ent.cat   = req_chan.category;
      dec.ent.price = req_chan.price;
      dec.upper     = req_chan.price_upper;
      dec.mode      = MODE_ALL;
      unique case (req_chan.opcode)
         OP_INSERT:     dec.kind = KIND_INSERT;
         OP_REMOVE:     dec.kind = KIND_REMOVE;
         OP_LOOKUP:     dec.kind = KIND_LOOKUP;
         OP_LIST_ALL:   dec.kind = KIND_LIST;
         OP_LIST_CAT: begin
            dec.kind = KIND_LIST;
            dec.mode = MODE_CAT;
         end
         OP_LIST_RANGE: begin
            dec.kind = KIND_LIST;
            dec.mode = MODE_RANGE;
         end
         default:       dec.kind = KIND_BAD;
      endcase
   end

   assign req_chan.ready = (fill_ff != 2'd2);
   assign cmd_valid      = (fill_ff != 2'd0);
   assign cmd            = q_ff[rp_ff];
   assign push           = req_chan.valid && req_chan.ready;
   assign pop            = cmd_valid && cmd_ready;

   always_comb begin
      wp_in   = push ? ~wp_ff : wp_ff;
      rp_in   = pop ? ~rp_ff : rp_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= dec;
      end
   end
endmodule

// ===== design/psit_back.sv =====
// Back end: runs one command at a time over the sorted entry memory and
// drives the registered response channel. Depends on psit_pkg, psit_rsp_if.
`include "price_sorted_item_table_defines.svh"
module psit_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  psit_pkg::cmd_type cmd,
   psit_rsp_if.source        rsp_chan
);
   import psit_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_RD    = 3'd2;
   localparam logic [2:0] S_EV    = 3'd3;
   localparam logic [2:0] S_PUT   = 3'd4;
   localparam logic [2:0] S_SRD   = 3'd5;
   localparam logic [2:0] S_SEV   = 3'd6;
   localparam logic [2:0] S_FIN   = 3'd7;

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   logic [2:0]          state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in, idx_ff, idx_in, idx_nx, idx_m1;
   entry_type           pend_ff, pend_in;
   logic                have_ff, have_in;

   logic                rsp_valid_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   entry_type           rsp_ent_ff;
   logic                rsp_last_ff;

   logic                rd_en, wr_en, emit, emit_last, out_free, stall, hit;
   logic [IDX_BITS-1:0] rd_addr, wr_addr;
   entry_type           wr_data, emit_ent, d;
   logic [STATUS_BITS-1:0] emit_status;

   assign d        = rd_data_ff;
   assign idx_nx   = idx_ff + CNT_BITS'(1);
   assign idx_m1   = idx_ff - CNT_BITS'(1);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign stall    = emit && !out_free;

   always_comb begin
      case (cmd_ff.mode)
         MODE_CAT:   hit = (d.cat == cmd_ff.ent.cat);
         MODE_RANGE: hit = (d.price >= cmd_ff.ent.price) && (d.price <= cmd_ff.upper);
         default:    hit = 1'b1;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      have_in     = have_ff;
      cmd_ready   = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = idx_ff[IDX_BITS-1:0];
      wr_en       = 1'b0;
      wr_addr     = idx_ff[IDX_BITS-1:0];
      wr_data     = d;
      emit        = 1'b0;
      emit_status = ST_NOT_FOUND;
      emit_ent    = '0;
      emit_last   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in   = cmd;
               state_in = S_START;
            end
         end
         S_START: begin
            have_in = 1'b0;
            if (cmd_ff.kind == KIND_INSERT) begin
               if (cnt_ff == CNT_BITS'(CAPACITY)) begin
                  emit        = 1'b1;
                  emit_status = ST_FULL;
                  emit_ent    = cmd_ff.ent;
                  state_in    = S_IDLE;
               end else begin
                  idx_in   = cnt_ff;
                  state_in = (cnt_ff == '0) ? S_PUT : S_RD;
               end
            end else if (cmd_ff.kind == KIND_BAD || cnt_ff == '0) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in   = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            rd_addr  = (cmd_ff.kind == KIND_INSERT) ? idx_m1[IDX_BITS-1:0]
                                                    : idx_ff[IDX_BITS-1:0];
            state_in = S_EV;
         end
         S_EV: begin
            if (cmd_ff.kind == KIND_INSERT) begin
               if (d.price > cmd_ff.ent.price) begin
                  wr_en    = 1'b1;
                  idx_in   = idx_m1;
                  state_in = (idx_m1 == '0) ? S_PUT : S_RD;
               end else begin
                  state_in = S_PUT;
               end
            end else if (cmd_ff.kind == KIND_LIST) begin
               if (hit) begin
                  if (have_ff) begin
                     emit        = 1'b1;
                     emit_status = ST_DONE;
                     emit_ent    = pend_ff;
                     emit_last   = 1'b0;
                  end
                  pend_in = d;
                  have_in = 1'b1;
               end
               idx_in   = idx_nx;
               state_in = (idx_nx == cnt_ff) ? S_FIN : S_RD;
            end else if (d.key == cmd_ff.ent.key) begin
               emit        = 1'b1;
               emit_status = ST_DONE;
               emit_ent    = d;
               state_in    = S_IDLE;
               if (cmd_ff.kind == KIND_REMOVE) begin
                  if (idx_nx < cnt_ff) begin
                     state_in = S_SRD;
                  end else begin
                     cnt_in = cnt_ff - CNT_BITS'(1);
                  end
               end
            end else if (idx_nx == cnt_ff) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_nx;
               state_in = S_RD;
            end
         end
         S_PUT: begin
            wr_en       = 1'b1;
            wr_data     = cmd_ff.ent;
            cnt_in      = cnt_ff + CNT_BITS'(1);
            emit        = 1'b1;
            emit_status = ST_INSERTED;
            emit_ent    = cmd_ff.ent;
            state_in    = S_IDLE;
         end
         S_SRD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_nx[IDX_BITS-1:0];
            state_in = S_SEV;
         end
         S_SEV: begin
            wr_en  = 1'b1;
            idx_in = idx_nx;
            if ((idx_nx + CNT_BITS'(1)) < cnt_ff) begin
               state_in = S_SRD;
            end else begin
               cnt_in   = cnt_ff - CNT_BITS'(1);
               state_in = S_IDLE;
            end
         end
         S_FIN: begin
            emit     = 1'b1;
            state_in = S_IDLE;
            if (have_ff) begin
               emit_status = ST_DONE;
               emit_ent    = pend_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         have_ff  <= 1'b0;
      end else if (!stall) begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         have_ff  <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         cmd_ff  <= cmd_in;
         idx_ff  <= idx_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && !stall) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && out_free) begin
         rsp_status_ff <= emit_status;
         rsp_ent_ff    <= emit_ent;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.out_key      = rsp_ent_ff.key;
   assign rsp_chan.out_category = rsp_ent_ff.cat;
   assign rsp_chan.out_price    = rsp_ent_ff.price;
   assign rsp_chan.last         = rsp_last_ff;

   `PSIT_ASSERT_ALWAYS(a_cnt_cap, cnt_ff <= CNT_BITS'(CAPACITY), "entry count over capacity")
   `PSIT_ASSERT_IMPL(a_walk_nonempty, state_ff == S_RD || state_ff == S_EV, cnt_ff != '0, "walk over empty table")
   `PSIT_ASSERT_IMPL(a_shift_room, state_ff == S_SRD || state_ff == S_SEV, idx_nx < cnt_ff, "remove shift past end")
endmodule

// ===== design/price_sorted_item_table.sv =====
// Price sorted item table: one request in, one or more responses out. The
// table lives in a single-port memory with a registered read, so a command
// reads the stored entries one at a time. An insert, remove or listing may
// visit every stored entry; an insert or lookup stops early once its insert
// point or key match is found. Commands stall when the response
// side is not ready. Up to two requests queue ahead of the one in progress.
// Depends on psit_pkg, psit_if, psit_front and psit_back.
module price_sorted_item_table (
   input logic         clock,
   input logic         reset,
   psit_req_if.sink    req_chan,
   psit_rsp_if.source  rsp_chan
);
   import psit_pkg::*;

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   psit_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   psit_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_chan  (rsp_chan)
   );
endmodule

// ===== bench/psit_tb_files.sv =====
`timescale 1ns / 100ps
// Shared request and response records for the price sorted item table bench.
// Depends on psit_pkg.
package psit_tb_pkg;
   import psit_pkg::*;

   typedef struct packed {
      logic [OP_BITS-1:0]    op;
      logic [KEY_BITS-1:0]   key;
      logic [CAT_BITS-1:0]   cat;
      logic [PRICE_BITS-1:0] lo;
      logic [PRICE_BITS-1:0] hi;
   } request_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [KEY_BITS-1:0]    key;
      logic [CAT_BITS-1:0]    cat;
      logic [PRICE_BITS-1:0]  price;
      logic                   last;
   } response_type;
endpackage

// ===== bench/price_sorted_item_table_tb.sv =====
`timescale 1ns / 100ps
// Testbench for price_sorted_item_table: directed table then random requests,
// responses checked against a behavioral sorted-table model.
// Depends on psit_pkg, psit_tb_pkg, psit_if and the RTL.
module price_sorted_item_table_tb;
   import psit_pkg::*;
   import psit_tb_pkg::*;

   localparam int LIMIT = 2000000;
   localparam logic [OP_BITS-1:0] OP_SPARE = 3'd6;

   typedef struct {
      request_type  req;
      logic         typed;
      response_type rsp;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   psit_req_if req_chan ();
   psit_rsp_if rsp_chan ();

   price_sorted_item_table u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #5 clock = ~clock;

   entry_type    table_entries[$];
   response_type pending_rsps[$];
   int           mismatches = 0;
   int           cycles = 0;
   bit           quiet = 1'b0;
   bit           hold_off = 1'b0;
   bit           stim_done = 1'b0;
   int           req_count = 0;

   task automatic report(input string what, input response_type got,
                         input response_type want);
      mismatches++;
      $display("MISMATCH %s: got st=%0d k=%h c=%0d p=%h l=%0d, want st=%0d k=%h c=%0d p=%h l=%0d",
               what, got.status, got.key, got.cat, got.price, got.last,
               want.status, want.key, want.cat, want.price, want.last);
   endtask

   function automatic response_type mk(input logic [STATUS_BITS-1:0] st,
                                       input entry_type e, input logic l);
      response_type r;
      r.status = st;
      r.key    = e.key;
      r.cat    = e.cat;
      r.price  = e.price;
      r.last   = l;
      return r;
   endfunction

   function automatic bit listed(input request_type r, input entry_type e);
      case (r.op)
         OP_LIST_CAT:   return e.cat == r.cat;
         OP_LIST_RANGE: return e.price >= r.lo && e.price <= r.hi;
         default:       return 1'b1;
      endcase
   endfunction

   task automatic apply_to_table(input request_type r);
      entry_type e;
      int        pos;
      int        lastpos;
      e = '{key: r.key, cat: r.cat, price: r.lo};
      pos = -1;
      lastpos = -1;
      case (r.op)
         OP_INSERT: begin
            if (table_entries.size() >= CAPACITY) begin
               pending_rsps.push_back(mk(ST_FULL, e, 1'b1));
            end else begin
               pos = 0;
               while (pos < table_entries.size() && table_entries[pos].price <= r.lo) pos++;
               table_entries.insert(pos, e);
               pending_rsps.push_back(mk(ST_INSERTED, e, 1'b1));
            end
         end
         OP_REMOVE, OP_LOOKUP: begin
            foreach (table_entries[i])
               if (pos < 0 && table_entries[i].key == r.key) pos = i;
            if (pos < 0) begin
               pending_rsps.push_back(mk(ST_NOT_FOUND, '0, 1'b1));
            end else begin
               pending_rsps.push_back(mk(ST_DONE, table_entries[pos], 1'b1));
               if (r.op == OP_REMOVE) table_entries.delete(pos);
            end
         end
         OP_LIST_ALL, OP_LIST_CAT, OP_LIST_RANGE: begin
            foreach (table_entries[i])
               if (listed(r, table_entries[i])) lastpos = i;
            if (lastpos < 0) pending_rsps.push_back(mk(ST_NOT_FOUND, '0, 1'b1));
            foreach (table_entries[i])
               if (listed(r, table_entries[i]))
                  pending_rsps.push_back(mk(ST_DONE, table_entries[i], i == lastpos));
         end
         default: pending_rsps.push_back(mk(ST_NOT_FOUND, '0, 1'b1));
      endcase
   endtask

   // request side
   task automatic send(input request_type r);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.opcode      <= r.op;
      req_chan.item_key    <= r.key;
      req_chan.category    <= r.cat;
      req_chan.price       <= r.lo;
      req_chan.price_upper <= r.hi;
      do @(posedge clock); while (!req_chan.ready);
      apply_to_table(r);
      req_count++;
   endtask

   // directed row: typed expectation checked against model prediction
   task automatic send_row(input row_type row);
      int prior;
      prior = pending_rsps.size();
      send(row.req);
      if (row.typed && pending_rsps.size() == prior + 1 &&
          pending_rsps[prior] != row.rsp)
         report("directed", pending_rsps[prior], row.rsp);
   endtask

   function automatic request_type rand_req(input int phase);
      request_type r;
      int          pick;
      r.op  = OP_SPARE;
      r.key = (phase == 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
      r.cat = 2'($urandom);
      r.lo  = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 40));
      r.hi  = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 40));
      pick = $urandom_range(0, 99);
      if (pick < 40)      r.op = OP_INSERT;
      else if (pick < 55) r.op = OP_REMOVE;
      else if (pick < 68) r.op = OP_LOOKUP;
      else if (pick < 76) r.op = OP_LIST_ALL;
      else if (pick < 86) r.op = OP_LIST_CAT;
      else if (pick < 97) r.op = OP_LIST_RANGE;
      else                r.op = 3'($urandom_range(6, 7));
      return r;
   endfunction

   initial begin
      row_type     rows[$];
      request_type r;
      entry_type   e;
      req_chan.valid       <= 1'b0;
      req_chan.opcode      <= OP_INSERT;
      req_chan.item_key    <= '0;
      req_chan.category    <= '0;
      req_chan.price       <= '0;
      req_chan.price_upper <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      e = '{key: 16'hFFFF, cat: 2'd3, price: 24'hFFFFFF};
      rows.push_back('{'{OP_LIST_ALL, 16'd0, 2'd0, 24'd0, 24'hFFFFFF}, 1'b1,
                       mk(ST_NOT_FOUND, '0, 1'b1)});
      rows.push_back('{'{OP_REMOVE, 16'd5, 2'd0, 24'd0, 24'd0}, 1'b1,
                       mk(ST_NOT_FOUND, '0, 1'b1)});
      rows.push_back('{'{OP_INSERT, 16'hFFFF, 2'd3, 24'hFFFFFF, 24'd0}, 1'b1,
                       mk(ST_INSERTED, e, 1'b1)});
      rows.push_back('{'{OP_INSERT, 16'd0, 2'd0, 24'd0, 24'd0}, 1'b1,
                       mk(ST_INSERTED, '0, 1'b1)});
      rows.push_back('{'{OP_INSERT, 16'd7, 2'd1, 24'd100, 24'd0}, 1'b0, '0});
      rows.push_back('{'{OP_INSERT, 16'd7, 2'd2, 24'd100, 24'd0}, 1'b0, '0});
      rows.push_back('{'{OP_INSERT, 16'hAAAA, 2'd1, 24'h555555, 24'd0}, 1'b0, '0});
      rows.push_back('{'{OP_LIST_ALL, 16'd0, 2'd0, 24'd0, 24'd0}, 1'b0, '0});
      rows.push_back('{'{OP_LIST_CAT, 16'd0, 2'd1, 24'd0, 24'd0}, 1'b0, '0});
      rows.push_back('{'{OP_LIST_CAT, 16'd0, 2'd3, 24'd0, 24'd0}, 1'b0, '0});
      rows.push_back('{'{OP_LIST_RANGE, 16'd0, 2'd0, 24'd100, 24'd100}, 1'b0, '0});
      rows.push_back('{'{OP_LIST_RANGE, 16'd0, 2'd0, 24'd200, 24'd100}, 1'b1,
                       mk(ST_NOT_FOUND, '0, 1'b1)});
      rows.push_back('{'{OP_LIST_RANGE, 16'd0, 2'd0, 24'd0, 24'hFFFFFF}, 1'b0, '0});
      rows.push_back('{'{OP_LOOKUP, 16'd7, 2'd0, 24'd0, 24'd0}, 1'b0, '0});
      rows.push_back('{'{OP_REMOVE, 16'd7, 2'd0, 24'd0, 24'd0}, 1'b0, '0});
      rows.push_back('{'{OP_LOOKUP, 16'd7, 2'd0, 24'd0, 24'd0}, 1'b0, '0});
      rows.push_back('{'{OP_SPARE, 16'hFFFF, 2'd3, 24'hFFFFFF, 24'hFFFFFF}, 1'b1,
                       mk(ST_NOT_FOUND, '0, 1'b1)});
      rows.push_back('{'{3'd7, 16'd0, 2'd0, 24'd0, 24'd0}, 1'b1,
                       mk(ST_NOT_FOUND, '0, 1'b1)});
      foreach (rows[i]) send_row(rows[i]);

      // fill to capacity, then one more to hit the full case
      while (table_entries.size() < CAPACITY) begin
         r = rand_req(0);
         r.op = OP_INSERT;
         send(r);
      end
      e = '{key: 16'h1234, cat: 2'd2, price: 24'd77};
      send_row('{'{OP_INSERT, e.key, e.cat, e.price, 24'd0}, 1'b1, mk(ST_FULL, e, 1'b1)});
      send('{OP_LIST_ALL, 16'd0, 2'd0, 24'd0, 24'd0});
      while (table_entries.size() > 0) begin
         r = rand_req(0);
         r.op = OP_REMOVE;
         r.key = table_entries[$urandom_range(0, table_entries.size() - 1)].key;
         send(r);
      end

      // random phase; a long response stall partway through
      for (int n = 0; n < 370; n++) begin
         if (n == 120) hold_off = 1'b1;
         if (n == 290) quiet = 1'b1;
         r = rand_req(n < 240 ? 0 : 1);
         if (r.op == OP_REMOVE || r.op == OP_LOOKUP)
            if (table_entries.size() > 0 && $urandom_range(0, 3) != 0)
               r.key = table_entries[$urandom_range(0, table_entries.size() - 1)].key;
         send(r);
      end
      req_chan.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // response side
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      response_type got;
      cycles <= cycles + 1;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.status, rsp_chan.out_key, rsp_chan.out_category,
                 rsp_chan.out_price, rsp_chan.last};
         if (pending_rsps.size() == 0) begin
            report("unexpected", got, '0);
         end else begin
            if (got != pending_rsps[0]) report("response", got, pending_rsps[0]);
            void'(pending_rsps.pop_front());
         end
      end
   end

   initial begin
      wait (stim_done && pending_rsps.size() == 0);
      repeat (3 * CAPACITY + 20) @(posedge clock);
      if (mismatches == 0 && pending_rsps.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      wait (cycles >= LIMIT);
      $display("Mismatches found");
      $finish;
   end
endmodule
